>>> rtl/grid_weighted_shortest_path_defines.svh
// ----------------------------------------------------------------------------
// Grid weighted shortest path: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_WEIGHTED_SHORTEST_PATH_DEFINES_SVH
`define GRID_WEIGHTED_SHORTEST_PATH_DEFINES_SVH

// Overlapping implication checked at every rising edge outside reset.
`define GWSP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GWSP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/gwsp_pkg.sv
// ----------------------------------------------------------------------------
// Grid weighted shortest path: package
// Sizes, codes, state type and helper functions shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwsp_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int CELL_W      = ROW_W + COL_W;
   localparam int CELLS       = MAX_ROWS * MAX_COLS;
   localparam int CNT_W       = 7;
   localparam int DIST_W      = 13;
   localparam int LEN_W       = 12;
   localparam int QCNT_W      = CELL_W + 1;
   localparam int NUM_BUCKETS = 3;
   localparam int QDEPTH      = NUM_BUCKETS * CELLS;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SEARCH = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   localparam logic [1:0] TER_OPEN  = 2'd0;
   localparam logic [1:0] TER_WATER = 2'd1;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ROW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COL = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP,
      ST_CHECK,
      ST_CLEAR,
      ST_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_VISIT,
      ST_NEIGH,
      ST_RELAX,
      ST_FIND,
      ST_FIND_WAIT,
      ST_COUNT,
      ST_COUNT_WAIT,
      ST_TRACE,
      ST_TRACE_WAIT
   } state_type;

   // Saturates a row or column count into 1..max.
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] max);
      logic [CNT_W-1:0] r;
      if (v == '0) r = CNT_W'(1);
      else if (v > max) r = max;
      else r = v;
      return r;
   endfunction

   // Moves one cell against the arrival direction; wraps round the store.
   function automatic logic [CELL_W-1:0] step_back(input logic [CELL_W-1:0] pos,
                                                   input logic [1:0] dir);
      logic [CELL_W-1:0] r;
      case (dir)
         DIR_N:   r = pos + CELL_W'(MAX_COLS);
         DIR_E:   r = pos - CELL_W'(1);
         DIR_S:   r = pos - CELL_W'(MAX_COLS);
         default: r = pos + CELL_W'(1);
      endcase
      return r;
   endfunction

endpackage

>>> rtl/gwsp_ram.sv
// ----------------------------------------------------------------------------
// Grid weighted shortest path: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/grid_weighted_shortest_path.sv
// ----------------------------------------------------------------------------
// Grid weighted shortest path: top level
// Terrain grid store, bucket-queue shortest-path search and path read-back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | opcode, cell, terrain, step index
//  rsp     | out       | rsp_valid/rsp_ready   | summary, step direction, step flag
//  csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// A cell write or no-op goes straight to the response state, a path read
// passes the read state first. A search first clears the visited marks, one
// cell a cycle, then runs the queue loop: each pop passes the pop, pop-wait
// and visit states, and each neighbour is examined in the neighbour and relax
// states through the registered-read distance and terrain stores; then it
// makes two passes over the route, a step and a wait state for each move.
// Reset is synchronous; it clears the summary, start and target; rows and columns go to maximum.
// Only one transaction is in flight; req_ready is low until the response
// is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_weighted_shortest_path_defines.svh"

module grid_weighted_shortest_path
   import gwsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [5:0]            req_cell_row,
   input  logic [5:0]            req_cell_col,
   input  logic [1:0]            req_terrain,
   input  logic [11:0]           req_step_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_reachable,
   output logic [DIST_W-1:0]     rsp_distance,
   output logic [LEN_W-1:0]      rsp_path_length,
   output logic [1:0]            rsp_step_dir,
   output logic                  rsp_step_valid
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] num_rows_ff, num_cols_ff;
   logic [ROW_W-1:0] start_row_ff, target_row_ff;
   logic [COL_W-1:0] start_col_ff, target_col_ff;

   logic              sum_reach_ff, sum_reach_in;
   logic [DIST_W-1:0] sum_dist_ff, sum_dist_in;
   logic [LEN_W-1:0]  sum_len_ff, sum_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        step_dir_ff, step_dir_in;
   logic              step_valid_ff, step_valid_in;

   logic [DIST_W-1:0] d_ff, d_in;
   logic [1:0]        b_ff, b_in;
   logic [CELL_W-1:0] qhead_ff [NUM_BUCKETS];
   logic [CELL_W-1:0] qhead_in [NUM_BUCKETS];
   logic [QCNT_W-1:0] qcnt_ff [NUM_BUCKETS];
   logic [QCNT_W-1:0] qcnt_in [NUM_BUCKETS];
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [CELL_W-1:0] nb_ff, nb_in;
   logic [1:0]        dir_ff, dir_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QCNT_W-1:0] k_ff, k_in;
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [DIST_W-1:0] tdist_ff, tdist_in;

   // Memory ports
   logic                        ter_we;
   logic [CELL_W-1:0]           ter_waddr, ter_raddr;
   logic [1:0]                  ter_wdata, ter_rdata;
   logic                        dist_we;
   logic [CELL_W-1:0]           dist_waddr, dist_raddr;
   logic [DIST_W:0]             dist_wdata, dist_rdata;
   logic                        arr_we;
   logic [CELL_W-1:0]           arr_waddr, arr_raddr;
   logic [1:0]                  arr_wdata, arr_rdata;
   logic                        q_we;
   logic [$clog2(QDEPTH)-1:0]   q_waddr, q_raddr;
   logic [CELL_W-1:0]           q_wdata, q_rdata;
   logic                        path_we;
   logic [CELL_W-1:0]           path_waddr, path_raddr;
   logic [1:0]                  path_wdata, path_rdata;

   // Shared conditions
   logic [CNT_W-1:0]  rows, cols;
   logic [CELL_W-1:0] start_cell, target_cell;
   logic              accept, out_of_grid, queues_empty;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic              nb_ok;
   logic [CELL_W-1:0] nb_cell;
   logic              ter_ok, relax_ok;
   logic [2:0]        weight;
   logic [2:0]        bkt_sum;
   logic [1:0]        nb_bkt;
   logic [DIST_W-1:0] nd;
   logic [QCNT_W+1:0] q_total;
   logic              route_held, queues_bounded;

   assign rows        = clamp_count(num_rows_ff, CNT_W'(MAX_ROWS));
   assign cols        = clamp_count(num_cols_ff, CNT_W'(MAX_COLS));
   assign start_cell  = {start_row_ff, start_col_ff};
   assign target_cell = {target_row_ff, target_col_ff};
   assign accept      = req_valid && req_ready;
   assign out_of_grid = ({1'b0, start_row_ff} >= rows) || ({1'b0, start_col_ff} >= cols) ||
                        ({1'b0, target_row_ff} >= rows) || ({1'b0, target_col_ff} >= cols);
   assign q_total     = (QCNT_W+2)'(qcnt_ff[0]) + (QCNT_W+2)'(qcnt_ff[1]) +
                        (QCNT_W+2)'(qcnt_ff[2]);
   assign queues_empty = (q_total == '0);

   assign cur_row = cell_ff[CELL_W-1:COL_W];
   assign cur_col = cell_ff[COL_W-1:0];

   always_comb begin
      case (dir_ff)
         DIR_N: begin
            nb_ok   = (cur_row != '0);
            nb_cell = cell_ff - CELL_W'(MAX_COLS);
         end
         DIR_E: begin
            nb_ok   = ({1'b0, cur_col} + CNT_W'(1)) < cols;
            nb_cell = cell_ff + CELL_W'(1);
         end
         DIR_S: begin
            nb_ok   = ({1'b0, cur_row} + CNT_W'(1)) < rows;
            nb_cell = cell_ff + CELL_W'(MAX_COLS);
         end
         default: begin
            nb_ok   = (cur_col != '0);
            nb_cell = cell_ff - CELL_W'(1);
         end
      endcase
   end

   // Terrain codes two and three are both impassable.
   assign ter_ok   = (ter_rdata == TER_OPEN) || (ter_rdata == TER_WATER);
   assign weight   = (ter_rdata == TER_WATER) ? 3'd2 : 3'd1;
   assign nd       = d_ff + DIST_W'(weight);
   assign bkt_sum  = {1'b0, b_ff} + weight;
   assign nb_bkt   = (bkt_sum >= 3'd3) ? 2'(bkt_sum - 3'd3) : bkt_sum[1:0];
   assign relax_ok = ter_ok && (!dist_rdata[DIST_W] || (dist_rdata[DIST_W-1:0] > nd));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_SEARCH: state_in = ST_CHECK;
                  OP_READ:   state_in = ST_READ;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_READ:  state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         ST_CHECK: state_in = out_of_grid ? ST_RESP : ST_CLEAR;
         ST_CLEAR: if (cnt_ff[CELL_W-1:0] == '1) state_in = ST_INIT;
         ST_INIT:  state_in = ST_POP;
         ST_POP: begin
            if (queues_empty) state_in = ST_FIND;
            else if (qcnt_ff[b_ff] != '0) state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: state_in = ST_VISIT;
         ST_VISIT: begin
            if (dist_rdata[DIST_W-1:0] != d_ff) state_in = ST_POP;
            else if (cell_ff == target_cell) state_in = ST_FIND;
            else state_in = ST_NEIGH;
         end
         ST_NEIGH: begin
            if (nb_ok) state_in = ST_RELAX;
            else if (dir_ff == DIR_W) state_in = ST_POP;
         end
         ST_RELAX:     state_in = (dir_ff == DIR_W) ? ST_POP : ST_NEIGH;
         ST_FIND:      state_in = ST_FIND_WAIT;
         ST_FIND_WAIT: state_in = dist_rdata[DIST_W] ? ST_COUNT : ST_RESP;
         ST_COUNT: begin
            if (cur_ff == start_cell || cnt_ff == QCNT_W'(CELLS)) state_in = ST_TRACE;
            else state_in = ST_COUNT_WAIT;
         end
         ST_COUNT_WAIT: state_in = ST_COUNT;
         ST_TRACE:      state_in = (k_ff == cnt_ff) ? ST_RESP : ST_TRACE_WAIT;
         ST_TRACE_WAIT: state_in = ST_TRACE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      sum_reach_in  = sum_reach_ff;
      sum_dist_in   = sum_dist_ff;
      sum_len_in    = sum_len_ff;
      rsp_valid_in  = rsp_valid_ff;
      step_dir_in   = step_dir_ff;
      step_valid_in = step_valid_ff;
      d_in          = d_ff;
      b_in          = b_ff;
      qhead_in      = qhead_ff;
      qcnt_in       = qcnt_ff;
      cell_in       = cell_ff;
      nb_in         = nb_ff;
      dir_in        = dir_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      cur_in        = cur_ff;
      tdist_in      = tdist_ff;

      ter_we     = 1'b0;
      ter_waddr  = {req_cell_row, req_cell_col};
      ter_wdata  = req_terrain;
      ter_raddr  = nb_cell;
      dist_we    = 1'b0;
      dist_waddr = nb_ff;
      dist_wdata = {1'b1, nd};
      dist_raddr = nb_cell;
      arr_we     = 1'b0;
      arr_waddr  = nb_ff;
      arr_wdata  = dir_ff;
      arr_raddr  = cur_ff;
      q_we       = 1'b0;
      q_waddr    = {nb_bkt, qhead_ff[nb_bkt] + qcnt_ff[nb_bkt][CELL_W-1:0]};
      q_wdata    = nb_ff;
      q_raddr    = {b_ff, qhead_ff[b_ff]};
      path_we    = 1'b0;
      path_waddr = 12'(cnt_ff - k_ff - QCNT_W'(1));
      path_wdata = arr_rdata;
      path_raddr = req_step_index;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_dir_in   = DIR_N;
               step_valid_in = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_WRITE: begin
                     // Row and column ports cannot exceed the store here.
                     ter_we       = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SEARCH: begin
                     sum_reach_in = 1'b0;
                     sum_dist_in  = '0;
                     sum_len_in   = '0;
                  end
                  OP_READ: step_valid_in = (req_step_index < sum_len_ff);
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            step_dir_in  = step_valid_ff ? path_rdata : DIR_N;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) rsp_valid_in = 1'b0;
         end
         ST_CHECK: begin
            cnt_in = '0;
            if (out_of_grid) rsp_valid_in = 1'b1;
         end
         ST_CLEAR: begin
            // Visited marks are cleared; the distances behind them are don't-care.
            dist_we    = 1'b1;
            dist_waddr = cnt_ff[CELL_W-1:0];
            dist_wdata = '0;
            cnt_in     = cnt_ff + QCNT_W'(1);
         end
         ST_INIT: begin
            dist_we    = 1'b1;
            dist_waddr = start_cell;
            dist_wdata = {1'b1, {DIST_W{1'b0}}};
            q_we       = 1'b1;
            q_waddr    = '0;
            q_wdata    = start_cell;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
               qhead_in[i] = '0;
               qcnt_in[i]  = '0;
            end
            qcnt_in[0] = QCNT_W'(1);
            d_in       = '0;
            b_in       = 2'd0;
         end
         ST_POP: begin
            if (!queues_empty) begin
               if (qcnt_ff[b_ff] == '0) begin
                  d_in = d_ff + DIST_W'(1);
                  b_in = (b_ff == 2'd2) ? 2'd0 : b_ff + 2'd1;
               end else begin
                  qhead_in[b_ff] = qhead_ff[b_ff] + CELL_W'(1);
                  qcnt_in[b_ff]  = qcnt_ff[b_ff] - QCNT_W'(1);
               end
            end
         end
         ST_POP_WAIT: begin
            cell_in    = q_rdata;
            dist_raddr = q_rdata;
         end
         ST_VISIT: dir_in = DIR_N;
         ST_NEIGH: begin
            if (nb_ok) nb_in = nb_cell;
            else dir_in = dir_ff + 2'd1;
         end
         ST_RELAX: begin
            if (relax_ok) begin
               dist_we = 1'b1;
               arr_we  = 1'b1;
               if (qcnt_ff[nb_bkt] < QCNT_W'(CELLS)) begin
                  q_we            = 1'b1;
                  qcnt_in[nb_bkt] = qcnt_ff[nb_bkt] + QCNT_W'(1);
               end
            end
            dir_in = dir_ff + 2'd1;
         end
         ST_FIND: dist_raddr = target_cell;
         ST_FIND_WAIT: begin
            tdist_in = dist_rdata[DIST_W-1:0];
            cur_in   = target_cell;
            cnt_in   = '0;
            if (!dist_rdata[DIST_W]) rsp_valid_in = 1'b1;
         end
         ST_COUNT: begin
            if (cur_ff == start_cell || cnt_ff == QCNT_W'(CELLS)) begin
               cur_in = target_cell;
               k_in   = '0;
            end
         end
         ST_COUNT_WAIT: begin
            cur_in = step_back(cur_ff, arr_rdata);
            cnt_in = cnt_ff + QCNT_W'(1);
         end
         ST_TRACE: begin
            if (k_ff == cnt_ff) begin
               sum_reach_in = 1'b1;
               sum_dist_in  = tdist_ff;
               sum_len_in   = cnt_ff[LEN_W-1:0];
               rsp_valid_in = 1'b1;
            end
         end
         ST_TRACE_WAIT: begin
            path_we = 1'b1;
            cur_in  = step_back(cur_ff, arr_rdata);
            k_in    = k_ff + QCNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_rows_ff   <= CNT_W'(MAX_ROWS);
         num_cols_ff   <= CNT_W'(MAX_COLS);
         start_row_ff  <= '0;
         start_col_ff  <= '0;
         target_row_ff <= '0;
         target_col_ff <= '0;
         sum_reach_ff  <= 1'b0;
         sum_dist_ff   <= '0;
         sum_len_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_reach_ff <= sum_reach_in;
         sum_dist_ff  <= sum_dist_in;
         sum_len_ff   <= sum_len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_NUM_ROWS:   num_rows_ff   <= csr_wdata;
               CSR_NUM_COLS:   num_cols_ff   <= csr_wdata;
               CSR_START_ROW:  start_row_ff  <= csr_wdata[ROW_W-1:0];
               CSR_START_COL:  start_col_ff  <= csr_wdata[COL_W-1:0];
               CSR_TARGET_ROW: target_row_ff <= csr_wdata[ROW_W-1:0];
               CSR_TARGET_COL: target_col_ff <= csr_wdata[COL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      step_dir_ff   <= step_dir_in;
      step_valid_ff <= step_valid_in;
      d_ff          <= d_in;
      b_ff          <= b_in;
      qhead_ff      <= qhead_in;
      qcnt_ff       <= qcnt_in;
      cell_ff       <= cell_in;
      nb_ff         <= nb_in;
      dir_ff        <= dir_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      cur_ff        <= cur_in;
      tdist_ff      <= tdist_in;
   end

   gwsp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_terrain_ram (
      .clock(clock), .wr_en(ter_we), .wr_addr(ter_waddr), .wr_data(ter_wdata),
      .rd_addr(ter_raddr), .rd_data(ter_rdata)
   );

   // Each entry holds a visited mark above the distance.
   gwsp_ram #(.WIDTH(DIST_W + 1), .DEPTH(CELLS)) u_distance_ram (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_waddr), .wr_data(dist_wdata),
      .rd_addr(dist_raddr), .rd_data(dist_rdata)
   );

   gwsp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_arrival_ram (
      .clock(clock), .wr_en(arr_we), .wr_addr(arr_waddr), .wr_data(arr_wdata),
      .rd_addr(arr_raddr), .rd_data(arr_rdata)
   );

   // Three ring buffers side by side, selected by the upper address bits.
   gwsp_ram #(.WIDTH(CELL_W), .DEPTH(QDEPTH)) u_bucket_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   gwsp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_path_ram (
      .clock(clock), .wr_en(path_we), .wr_addr(path_waddr), .wr_data(path_wdata),
      .rd_addr(path_raddr), .rd_data(path_rdata)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reachable   = sum_reach_ff;
   assign rsp_distance    = sum_dist_ff;
   assign rsp_path_length = sum_len_ff;
   assign rsp_step_dir    = step_dir_ff;
   assign rsp_step_valid  = step_valid_ff;

   assign route_held     = sum_reach_ff && (sum_len_ff != '0);
   assign queues_bounded = (qcnt_ff[0] <= QCNT_W'(CELLS)) &&
                           (qcnt_ff[1] <= QCNT_W'(CELLS)) &&
                           (qcnt_ff[2] <= QCNT_W'(CELLS));

   `GWSP_ASSERT_IMP(a_ready_no_resp, req_ready, !rsp_valid, "ready with a response pending")
   `GWSP_ASSERT_NXT(a_accept_blocks, req_valid && req_ready, !req_ready, "taken while busy")
   `GWSP_ASSERT_IMP(a_step_in_path, rsp_valid && rsp_step_valid, route_held, "stray step flag")
   `GWSP_ASSERT_IMP(a_queue_bound, state_ff == ST_POP, queues_bounded, "bucket overfilled")

endmodule
